FILE: src/life_pkg.sv
// Shared constants, codes, types, the pattern-mask function and the cell-update function for the life grid.
// No dependencies; life_dp, life_ctrl, the top level and the testbench import this package.
`default_nettype none
package life_pkg;

    localparam int ROWS  = 64;
    localparam int COLS  = 64;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    // row pointer, wide enough to run a few rows past the grid during a spawn
    localparam int AW    = 8;

    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_STEP  = 3'd2;
    localparam logic [2:0] ACT_SPAWN = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [1:0] PAT_BLINKER = 2'd0;
    localparam logic [1:0] PAT_TOAD    = 2'd1;
    localparam logic [1:0] PAT_BEACON  = 2'd2;
    localparam logic [1:0] PAT_GLIDER  = 2'd3;

    typedef logic [COLS-1:0] t_row;

    typedef struct packed {
        logic       load;
        logic       rd;
        logic [1:0] rd_ofs;
        logic       rd_cap;
        logic       wr_cell;
        logic       sp_wr;
        logic       gen_init;
        logic       gen_prime;
        logic       gen_first;
        logic       gen_row;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       coord_ok;
        logic       gens_zero;
        logic       addr_in;
        logic       nxt2_in;
        logic       last_row;
        logic       gen_done;
        logic       k_done;
    } t_st;

    // Column mask of one pattern row; bit j is column offset j from the anchor.
    function automatic logic [3:0] life_pat_mask(input logic [1:0] pat, input logic [1:0] k);
        logic [3:0] m;
        m = 4'b0000;
        case (pat)
            PAT_BLINKER: m = (k == 2'd0) ? 4'b0111 : 4'b0000;
            PAT_TOAD: begin
                case (k)
                    2'd0:    m = 4'b1110;
                    2'd1:    m = 4'b0111;
                    default: m = 4'b0000;
                endcase
            end
            PAT_BEACON: m = k[1] ? 4'b1100 : 4'b0011;
            PAT_GLIDER: begin
                case (k)
                    2'd0:    m = 4'b0010;
                    2'd1:    m = 4'b0100;
                    2'd2:    m = 4'b0111;
                    default: m = 4'b0000;
                endcase
            end
            default: m = 4'b0000;
        endcase
        return m;
    endfunction

    // B3/S23 update of one row from its original neighbors; columns past the edge are dead.
    function automatic t_row life_next(input t_row up, input t_row mid, input t_row down);
        logic [COLS+1:0] ue;
        logic [COLS+1:0] me;
        logic [COLS+1:0] de;
        logic [3:0]      cnt;
        t_row            nr;
        ue = {1'b0, up, 1'b0};
        me = {1'b0, mid, 1'b0};
        de = {1'b0, down, 1'b0};
        for (int i = 0; i < COLS; i++) begin
            cnt = 4'(ue[i]) + 4'(ue[i+1]) + 4'(ue[i+2]) + 4'(me[i]) + 4'(me[i+2])
                + 4'(de[i]) + 4'(de[i+1]) + 4'(de[i+2]);
            nr[i] = (cnt == 4'd3) || (mid[i] && (cnt == 4'd2));
        end
        return nr;
    endfunction

endpackage
`default_nettype wire

FILE: src/life_if.sv
// Request and response channel interfaces of the life grid.
// Depends on nothing beyond the field widths fixed here.
`default_nettype none
interface life_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [6:0]  row;
    logic [6:0]  col;
    logic        cell_value;
    logic [15:0] generations;
    logic [1:0]  pattern;

    modport source (output valid, action, row, col, cell_value, generations, pattern,
                    input ready);
    modport sink   (input valid, action, row, col, cell_value, generations, pattern,
                    output ready);
endinterface

interface life_out_if;
    logic valid;
    logic ready;
    logic read_value;
    logic coord_ok;

    modport source (output valid, read_value, coord_ok, input ready);
    modport sink   (input valid, read_value, coord_ok, output ready);
endinterface
`default_nettype wire

FILE: src/life_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module life_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: src/life_dp.sv
// Datapath of the life grid: item registers, grid RAM with row valid bits,
// row window for the generation walk and pattern stamping. Uses life_pkg, life_ram.
`default_nettype none
module life_dp
    import life_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [2:0]  i_action,
    input  wire logic [6:0]  i_row,
    input  wire logic [6:0]  i_col,
    input  wire logic        i_cell_value,
    input  wire logic [15:0] i_generations,
    input  wire logic [1:0]  i_pattern,
    output t_st              o_st,
    output logic             o_read_value,
    output logic             o_coord_ok
);
    logic [2:0]      r_action;
    logic [6:0]      r_col;
    logic            r_value;
    logic [15:0]     r_gens;
    logic [1:0]      r_pat;
    logic            r_ok;
    logic            r_read;
    logic [AW-1:0]   r_addr;
    logic [2:0]      r_k;
    logic [15:0]     r_cnt;
    logic            r_changed;
    t_row            r_up;
    t_row            r_mid;
    logic [ROWS-1:0] r_vld;
    logic            r_rd_vld;

    logic            in_grid;
    logic            n_ok;
    logic [AW-1:0]   rd_addr;
    logic [ROW_W-1:0] rd_idx;
    logic [ROW_W-1:0] wr_idx;
    logic [6:0]      col_m1;
    logic [COL_W-1:0] col_idx;
    t_row            rdata;
    t_row            rdm;
    t_row            down;
    t_row            nr;
    logic            diff;
    logic [COLS+3:0] sp_wide;
    t_row            cell_row;
    t_row            wdata;
    logic            we;

    assign in_grid = (i_row >= 7'd1) && (i_row <= 7'(ROWS))
                  && (i_col >= 7'd1) && (i_col <= 7'(COLS));
    assign n_ok = ((i_action == ACT_READ) || (i_action == ACT_WRITE)
                || (i_action == ACT_SPAWN)) ? in_grid : 1'b1;

    // start each generation at the top row
    assign rd_addr = i_cmd.gen_prime ? AW'(0) : (r_addr + AW'(i_cmd.rd_ofs));
    assign rd_idx  = rd_addr[ROW_W-1:0];
    assign wr_idx  = r_addr[ROW_W-1:0];
    assign col_m1  = r_col - 7'd1;
    assign col_idx = col_m1[COL_W-1:0];

    assign rdm  = r_rd_vld ? rdata : '0;
    assign down = o_st.last_row ? '0 : rdm;
    assign nr   = life_next(r_up, r_mid, down);
    assign diff = (nr != r_mid);

    assign sp_wide = (COLS+4)'(life_pat_mask(r_pat, r_k[1:0])) << col_m1;

    always_comb begin
        cell_row = rdm;
        cell_row[col_idx] = r_value;
    end

    always_comb begin
        wdata = rdm | sp_wide[COLS-1:0];
        if (i_cmd.gen_row) begin
            wdata = nr;
        end else if (i_cmd.wr_cell) begin
            wdata = cell_row;
        end
    end
    assign we = i_cmd.gen_row || i_cmd.wr_cell || i_cmd.sp_wr;

    life_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_grid (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_idx),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_idx),
        .o_rdata (rdata)
    );

    // payload, read valid and row window registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_col    <= i_col;
            r_value  <= i_cell_value;
            r_gens   <= i_generations;
            r_pat    <= i_pattern;
            r_ok     <= n_ok;
        end
        if (i_cmd.rd) begin
            r_rd_vld <= r_vld[rd_idx];
        end
        if (i_cmd.gen_prime) begin
            r_up <= '0;
        end else if (i_cmd.gen_row) begin
            r_up <= r_mid;
        end
        if (i_cmd.gen_first) begin
            r_mid <= rdm;
        end else if (i_cmd.gen_row) begin
            r_mid <= down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_read    <= 1'b0;
            r_addr    <= '0;
            r_k       <= '0;
            r_cnt     <= '0;
            r_changed <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_vld <= '0;
            end else if (we) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (i_cmd.load) begin
                r_read <= 1'b0;
            end else if (i_cmd.rd_cap) begin
                r_read <= rdm[col_idx];
            end
            if (i_cmd.load) begin
                r_addr <= AW'(i_row) - AW'(1);
                r_k    <= '0;
            end else if (i_cmd.gen_prime) begin
                r_addr <= '0;
            end else if (i_cmd.gen_row || i_cmd.sp_wr) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.sp_wr) begin
                r_k <= r_k + 3'd1;
            end
            if (i_cmd.gen_init) begin
                r_cnt <= '0;
            end else if (i_cmd.gen_row && o_st.last_row) begin
                r_cnt <= r_cnt + 16'd1;
            end
            if (i_cmd.gen_prime) begin
                r_changed <= 1'b0;
            end else if (i_cmd.gen_row) begin
                r_changed <= r_changed | diff;
            end
        end
    end

    always_comb begin
        o_st.action    = r_action;
        o_st.coord_ok  = r_ok;
        o_st.gens_zero = (r_gens == 16'd0);
        o_st.addr_in   = (r_addr < AW'(ROWS));
        o_st.nxt2_in   = ((r_addr + AW'(2)) < AW'(ROWS));
        o_st.last_row  = (r_addr == AW'(ROWS - 1));
        // stop after the last row when nothing moved or the count is reached
        o_st.gen_done  = !(r_changed || diff) || ((r_cnt + 16'd1) == r_gens);
        o_st.k_done    = (r_k == 3'd4);
    end

    assign o_read_value = r_read;
    assign o_coord_ok   = r_ok;

    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (rd_addr < AW'(ROWS)))
        else $error("grid read past last row");
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_addr < AW'(ROWS)))
        else $error("grid write past last row");
    a_load_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> !r_read)
        else $error("read value not cleared on new item");
endmodule
`default_nettype wire

FILE: src/life_ctrl.sv
// Controller of the life grid: sequences reads, read-modify-writes, pattern
// stamping and the row walk of each generation. Uses life_pkg.
`default_nettype none
module life_ctrl
    import life_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_st  i_st,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_RD_DATA = 4'd2;
    localparam logic [3:0] S_WR_CELL = 4'd3;
    localparam logic [3:0] S_SP_RD   = 4'd4;
    localparam logic [3:0] S_SP_WR   = 4'd5;
    localparam logic [3:0] S_G_PRIME = 4'd6;
    localparam logic [3:0] S_G_FIRST = 4'd7;
    localparam logic [3:0] S_G_ROW   = 4'd8;
    localparam logic [3:0] S_RESP    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESP;
                case (i_st.action)
                    ACT_READ: begin
                        if (i_st.coord_ok) begin
                            o_cmd.rd = 1'b1;
                            n_state  = S_RD_DATA;
                        end
                    end
                    ACT_WRITE: begin
                        if (i_st.coord_ok) begin
                            o_cmd.rd = 1'b1;
                            n_state  = S_WR_CELL;
                        end
                    end
                    ACT_SPAWN: begin
                        if (i_st.coord_ok) begin
                            n_state = S_SP_RD;
                        end
                    end
                    ACT_STEP: begin
                        o_cmd.gen_init = 1'b1;
                        if (!i_st.gens_zero) begin
                            n_state = S_G_PRIME;
                        end
                    end
                    ACT_CLEAR: o_cmd.clear = 1'b1;
                    default:   n_state = S_RESP;
                endcase
            end
            S_RD_DATA: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = S_RESP;
            end
            S_WR_CELL: begin
                o_cmd.wr_cell = 1'b1;
                n_state       = S_RESP;
            end
            S_SP_RD: begin
                // drop pattern rows that fall below the grid
                if (i_st.k_done || !i_st.addr_in) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_SP_WR;
                end
            end
            S_SP_WR: begin
                o_cmd.sp_wr = 1'b1;
                n_state     = S_SP_RD;
            end
            S_G_PRIME: begin
                o_cmd.gen_prime = 1'b1;
                o_cmd.rd        = 1'b1;
                n_state         = S_G_FIRST;
            end
            S_G_FIRST: begin
                o_cmd.gen_first = 1'b1;
                o_cmd.rd        = 1'b1;
                o_cmd.rd_ofs    = 2'd1;
                n_state         = S_G_ROW;
            end
            S_G_ROW: begin
                o_cmd.gen_row = 1'b1;
                if (i_st.nxt2_in) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_ofs = 2'd2;
                end
                if (i_st.last_row) begin
                    n_state = i_st.gen_done ? S_RESP : S_G_PRIME;
                end
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open at once");
    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("response dropped while stalled");
endmodule
`default_nettype wire

FILE: src/life_cellular_automaton_grid.sv
// Top level of the B3/S23 life grid: joins controller and datapath to the channels.
// Depends on life_pkg, life_if, life_ctrl, life_dp (and life_ram below it).
//
//   channel  dir  modport  payload
//   i_req    in   sink     action, row, col, cell_value, generations, pattern
//   o_rsp    out  source   read_value, coord_ok
//
// One beat at a time: a request is taken only when the previous response has gone.
// After decode, a read or write does its RAM access, a spawn reads and writes each
// pattern row, and a step walks the grid one row per cycle; the grid RAM's single
// read port sets that walk. A step stops early after a generation with no change.
// Reset (synchronous, active low) clears the row valid bits, so the grid reads
// all dead at once with no clearing pass. A stalled response holds until taken.
`default_nettype none
module life_cellular_automaton_grid
    import life_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    life_in_if.sink   i_req,
    life_out_if.source o_rsp
);
    t_cmd cmd;
    t_st  st;

    life_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    life_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_req.action),
        .i_row         (i_req.row),
        .i_col         (i_req.col),
        .i_cell_value  (i_req.cell_value),
        .i_generations (i_req.generations),
        .i_pattern     (i_req.pattern),
        .o_st          (st),
        .o_read_value  (o_rsp.read_value),
        .o_coord_ok    (o_rsp.coord_ok)
    );
endmodule
`default_nettype wire

FILE: test/life_cellular_automaton_grid_tb.sv
// Testbench for life_cellular_automaton_grid: drives request beats, predicts each
// response with its own B3/S23 grid model and compares every response beat.
// Depends on life_pkg, life_if and the RTL of the grid.
`default_nettype none
module life_cellular_automaton_grid_tb;
    import life_pkg::*;

    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    // a long random step is only sent when the grid settles within this many generations
    localparam int SETTLE_CAP = 24;
    localparam int RANDOM_PER_PHASE = 375;

    typedef logic [COLS-1:0] t_grid_row;

    typedef struct packed {
        t_grid_row b2;
        t_grid_row b1;
        t_grid_row b0;
    } t_neighbor_count;

    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  row;
        logic [6:0]  col;
        logic        cell_value;
        logic [15:0] generations;
        logic [1:0]  pattern;
    } t_life_cmd;

    typedef struct packed {
        logic read_value;
        logic coord_ok;
    } t_life_rsp;

    logic clk = 1'b0;
    logic rst_n;

    life_in_if  req_ch ();
    life_out_if rsp_ch ();

    life_cellular_automaton_grid i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    t_grid_row life_grid  [ROWS];
    t_grid_row saved_grid [ROWS];
    t_life_rsp pending_results [$];
    int        mismatch_count = 0;
    int        req_idle_pct   = 0;
    int        rsp_stall_pct  = 0;

    // ---------------- grid model ----------------

    function automatic bit in_bounds(int r, int c);
        return r >= 1 && r <= ROWS && c >= 1 && c <= COLS;
    endfunction

    function automatic logic cell_at(int r, int c);
        if (!in_bounds(r, c)) begin
            return 1'b0;
        end
        return life_grid[r-1][c-1];
    endfunction

    function automatic void set_cell(int r, int c, logic v);
        if (in_bounds(r, c)) begin
            life_grid[r-1][c-1] = v;
        end
    endfunction

    // bit (4*row_offset + col_offset) marks a live cell of the shape
    function automatic logic [15:0] pattern_shape(logic [1:0] p);
        case (p)
            PAT_BLINKER: return 16'h0007;
            PAT_TOAD:    return 16'h007E;
            PAT_BEACON:  return 16'hCC33;
            default:     return 16'h0742;
        endcase
    endfunction

    function automatic t_neighbor_count tally(t_neighbor_count t, t_grid_row v);
        t_grid_row carry0;
        t_grid_row carry1;
        carry0 = t.b0 & v;
        t.b0   = t.b0 ^ v;
        carry1 = t.b1 & carry0;
        t.b1   = t.b1 ^ carry0;
        t.b2   = t.b2 ^ carry1;
        return t;
    endfunction

    // one synchronous generation, row by row with the original row above held
    function automatic bit advance_generation();
        t_grid_row       up;
        t_grid_row       mid;
        t_grid_row       dn;
        t_grid_row       fresh;
        t_neighbor_count t;
        bit              changed;
        changed = 1'b0;
        up = '0;
        for (int r = 0; r < ROWS; r++) begin
            mid = life_grid[r];
            dn  = (r + 1 < ROWS) ? life_grid[r+1] : '0;
            t   = '0;
            t   = tally(t, up << 1);
            t   = tally(t, up);
            t   = tally(t, up >> 1);
            t   = tally(t, mid << 1);
            t   = tally(t, mid >> 1);
            t   = tally(t, dn << 1);
            t   = tally(t, dn);
            t   = tally(t, dn >> 1);
            // count of 8 wraps to 0, which is dead anyway
            fresh = t.b1 & ~t.b2 & (t.b0 | mid);
            if (fresh != mid) begin
                changed = 1'b1;
            end
            life_grid[r] = fresh;
            up = mid;
        end
        return changed;
    endfunction

    function automatic int run_generations(int gens, int cap);
        int done;
        done = 0;
        while (done < gens && done < cap) begin
            done++;
            if (!advance_generation()) begin
                break;
            end
        end
        return done;
    endfunction

    // generations a step would run, up to the cap, leaving the grid untouched
    function automatic int settle_length(int gens);
        int n;
        for (int r = 0; r < ROWS; r++) begin
            saved_grid[r] = life_grid[r];
        end
        n = run_generations(gens, SETTLE_CAP);
        for (int r = 0; r < ROWS; r++) begin
            life_grid[r] = saved_grid[r];
        end
        return n;
    endfunction

    function automatic void apply_action(t_life_cmd cmd);
        t_life_rsp   rsp;
        int          r;
        int          c;
        logic [15:0] shape;
        r = int'(cmd.row);
        c = int'(cmd.col);
        rsp.read_value = 1'b0;
        rsp.coord_ok   = 1'b1;
        case (cmd.action)
            ACT_READ: begin
                rsp.coord_ok   = in_bounds(r, c);
                rsp.read_value = cell_at(r, c);
            end
            ACT_WRITE: begin
                rsp.coord_ok = in_bounds(r, c);
                set_cell(r, c, cmd.cell_value);
            end
            ACT_STEP: begin
                void'(run_generations(int'(cmd.generations), int'(cmd.generations)));
            end
            ACT_SPAWN: begin
                rsp.coord_ok = in_bounds(r, c);
                if (rsp.coord_ok) begin
                    shape = pattern_shape(cmd.pattern);
                    for (int k = 0; k < 16; k++) begin
                        if (shape[k]) begin
                            set_cell(r + k / 4, c + k % 4, 1'b1);
                        end
                    end
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < ROWS; i++) begin
                    life_grid[i] = '0;
                end
            end
            default: ;
        endcase
        pending_results.push_back(rsp);
    endfunction

    // ---------------- request side ----------------

    task automatic send_cmd(t_life_cmd cmd);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < req_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= cmd.action;
        req_ch.row         <= cmd.row;
        req_ch.col         <= cmd.col;
        req_ch.cell_value  <= cmd.cell_value;
        req_ch.generations <= cmd.generations;
        req_ch.pattern     <= cmd.pattern;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge clk);
        end
        apply_action(cmd);
    endtask

    task automatic issue(logic [2:0] act, int r, int c, logic v, logic [15:0] g,
                         logic [1:0] p);
        t_life_cmd cmd;
        cmd.action      = act;
        cmd.row         = 7'(r);
        cmd.col         = 7'(c);
        cmd.cell_value  = v;
        cmd.generations = g;
        cmd.pattern     = p;
        send_cmd(cmd);
    endtask

    // ---------------- response side ----------------

    initial begin
        t_life_rsp want;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected response read_value %b coord_ok %b",
                             $time, rsp_ch.read_value, rsp_ch.coord_ok);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_ch.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %b actual %b",
                                 $time, want.read_value, rsp_ch.read_value);
                        mismatch_count++;
                    end
                    if (rsp_ch.coord_ok !== want.coord_ok) begin
                        $display("%0t: coord_ok expected %b actual %b",
                                 $time, want.coord_ok, rsp_ch.coord_ok);
                        mismatch_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // ---------------- tests ----------------

    task automatic test_empty_reads();
        issue(ACT_READ, 1, 1, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_READ, ROWS, COLS, 1'b1, 16'hFFFF, PAT_GLIDER);
        issue(ACT_READ, 0, 0, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_READ, ROWS + 1, 1, 1'b0, 16'h0000, PAT_TOAD);
        issue(ACT_READ, 1, COLS + 1, 1'b0, 16'h0000, PAT_BEACON);
        issue(ACT_READ, 127, 127, 1'b1, 16'hFFFF, PAT_GLIDER);
    endtask

    task automatic test_cell_writes();
        issue(ACT_WRITE, 1, 1, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, 1, COLS, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, ROWS, 1, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, ROWS, COLS, 1'b1, 16'h0000, PAT_BLINKER);
        // writes off the grid are dropped
        issue(ACT_WRITE, 0, 3, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, 3, 0, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, 127, 127, 1'b1, 16'hFFFF, PAT_GLIDER);
        issue(ACT_READ, 1, COLS, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_READ, ROWS, COLS, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, 1, 1, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_READ, 1, 1, 1'b0, 16'h0000, PAT_BLINKER);
    endtask

    task automatic test_pattern_spawns();
        issue(ACT_CLEAR, 0, 0, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_SPAWN, 4, 4, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_SPAWN, 4, 12, 1'b0, 16'h0000, PAT_TOAD);
        issue(ACT_SPAWN, 4, 20, 1'b0, 16'h0000, PAT_BEACON);
        issue(ACT_SPAWN, 4, 28, 1'b0, 16'h0000, PAT_GLIDER);
        // clipped at the far corner, and an anchor off the grid
        issue(ACT_SPAWN, ROWS, COLS - 1, 1'b0, 16'h0000, PAT_GLIDER);
        issue(ACT_SPAWN, 0, 5, 1'b0, 16'h0000, PAT_BEACON);
        issue(ACT_READ, 5, 30, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_READ, ROWS, COLS, 1'b0, 16'h0000, PAT_BLINKER);
    endtask

    task automatic test_generation_steps();
        issue(ACT_STEP, 0, 0, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_STEP, 127, 127, 1'b1, 16'h0001, PAT_GLIDER);
        issue(ACT_STEP, 0, 0, 1'b0, 16'h0005, PAT_BLINKER);
        issue(ACT_READ, 5, 5, 1'b0, 16'h0000, PAT_BLINKER);
        // huge counts end after one generation on a settled grid
        issue(ACT_CLEAR, 127, 127, 1'b1, 16'hFFFF, PAT_GLIDER);
        issue(ACT_STEP, 0, 0, 1'b0, 16'hFFFF, PAT_BLINKER);
        issue(ACT_WRITE, 8, 8, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, 8, 9, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, 9, 8, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_WRITE, 9, 9, 1'b1, 16'h0000, PAT_BLINKER);
        issue(ACT_STEP, 0, 0, 1'b0, 16'hFFFF, PAT_BLINKER);
        issue(ACT_READ, 9, 9, 1'b0, 16'h0000, PAT_BLINKER);
    endtask

    task automatic test_spare_actions();
        issue(ACT_SPARE_5, 127, 127, 1'b1, 16'hFFFF, PAT_GLIDER);
        issue(ACT_SPARE_6, 0, 0, 1'b0, 16'h0000, PAT_BLINKER);
        issue(ACT_SPARE_7, 127, 127, 1'b1, 16'hFFFF, PAT_GLIDER);
    endtask

    function automatic logic [6:0] pick_coord(int base);
        if ($urandom_range(0, 99) < 8) begin
            return 7'($urandom_range(0, 127));
        end
        return 7'(base + $urandom_range(0, 9));
    endfunction

    function automatic int pick_base();
        case ($urandom_range(0, 2))
            0:       return 1;
            1:       return 28;
            default: return ROWS - 9;
        endcase
    endfunction

    task automatic test_random_traffic(int count);
        t_life_cmd cmd;
        int        roll;
        int        row_base;
        int        col_base;
        for (int n = 0; n < count; n++) begin
            // work in a small window so that cells meet and reads hit live ones
            if (n % 40 == 0) begin
                row_base = pick_base();
                col_base = pick_base();
            end
            cmd.row         = pick_coord(row_base);
            cmd.col         = pick_coord(col_base);
            cmd.cell_value  = ($urandom_range(0, 99) < 70);
            cmd.generations = 16'($urandom_range(0, 65535));
            cmd.pattern     = 2'($urandom_range(0, 3));
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                cmd.action = ACT_READ;
            end else if (roll < 55) begin
                cmd.action = ACT_WRITE;
            end else if (roll < 68) begin
                cmd.action = ACT_SPAWN;
            end else if (roll < 82) begin
                cmd.action = ACT_STEP;
                if ($urandom_range(0, 99) >= 15 ||
                    (cmd.generations > SETTLE_CAP &&
                     settle_length(int'(cmd.generations)) >= SETTLE_CAP)) begin
                    cmd.generations = 16'($urandom_range(0, 4));
                end
            end else if (roll < 87) begin
                cmd.action = ACT_CLEAR;
            end else if (roll < 90) begin
                case ($urandom_range(0, 2))
                    0:       cmd.action = ACT_SPARE_5;
                    1:       cmd.action = ACT_SPARE_6;
                    default: cmd.action = ACT_SPARE_7;
                endcase
            end else begin
                cmd.action = ACT_READ;
                cmd.row    = 7'($urandom_range(0, 127));
                cmd.col    = 7'($urandom_range(0, 127));
            end
            send_cmd(cmd);
        end
    endtask

    // ---------------- sequence ----------------

    initial begin
        for (int i = 0; i < ROWS; i++) begin
            life_grid[i] = '0;
        end
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_READ;
        req_ch.row         <= '0;
        req_ch.col         <= '0;
        req_ch.cell_value  <= 1'b0;
        req_ch.generations <= '0;
        req_ch.pattern     <= PAT_BLINKER;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_reads();
        test_cell_writes();
        test_pattern_spawns();
        test_generation_steps();
        test_spare_actions();

        req_idle_pct = 0;  rsp_stall_pct = 0;
        test_random_traffic(RANDOM_PER_PHASE);
        req_idle_pct = 67; rsp_stall_pct = 0;
        test_random_traffic(RANDOM_PER_PHASE);
        req_idle_pct = 0;  rsp_stall_pct = 67;
        test_random_traffic(RANDOM_PER_PHASE);
        req_idle_pct = 36; rsp_stall_pct = 36;
        test_random_traffic(RANDOM_PER_PHASE);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(64'd200_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

FILE: life_cellular_automaton_grid.f
src/life_pkg.sv
src/life_if.sv
src/life_ram.sv
src/life_dp.sv
src/life_ctrl.sv
src/life_cellular_automaton_grid.sv
test/life_cellular_automaton_grid_tb.sv
